[src/assert_macros.svh]
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that a condition is followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/ffha_pkg.sv]
// ============================================================================
// ffha_pkg
// Types and constants shared by the first-fit heap allocator modules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 12;
    localparam int SPLIT_SLACK  = 16;
    localparam int HDR_WORDS    = HEADER_BYTES / 4;
    localparam int DEPTH        = HEAP_BYTES / 4;
    localparam int SLOT_W       = $clog2(DEPTH);
    localparam int SIZE_W       = $clog2(HEAP_BYTES);
    localparam int REQ_W        = 16;
    localparam int NEED_W       = REQ_W + 1;
    localparam int CMP_W        = ((SIZE_W > NEED_W) ? SIZE_W : NEED_W) + 1;
    localparam int SUM_W        = ((SLOT_W > NEED_W - 2) ? SLOT_W : NEED_W - 2) + 1;
    localparam int ADDR_W       = 32;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 32'hC000_0000;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [REQ_W-1:0]  req_bytes;
        logic [ADDR_W-1:0] free_addr;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic              out_of_memory;
    } res_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [SLOT_W-1:0] next;
    } meta_t;

    typedef struct packed {
        logic              flag_we;
        logic              meta_we;
        logic [SLOT_W-1:0] waddr;
        logic              flag;
        meta_t             meta;
    } hdr_wr_t;

endpackage

`default_nettype wire

[src/ffha_ram.sv]
// ============================================================================
// ffha_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ffha_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    localparam int RAM_DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/ffha_walker.sv]
// ============================================================================
// ffha_walker
// Sequencer that walks the block chain, splits and marks headers, and holds
// the result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ffha_walker
    import ffha_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [ADDR_W-1:0] heap_base,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire cmd_t              cmd,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output res_t                   res,
    output logic      [SLOT_W-1:0] raddr,
    input  wire logic              flag_rdata,
    input  wire meta_t             meta_rdata,
    output hdr_wr_t                wr
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXAM,
        ST_SPLIT,
        ST_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;
    res_t              pend_reg, pend_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] ns_reg, ns_next;
    logic [NEED_W-1:0] need_reg, need_next;

    logic              accept;
    logic [NEED_W-1:0] need_cmd;
    logic [ADDR_W-1:0] free_off;
    logic              free_ok;
    logic [CMP_W-1:0]  size_ext;
    logic [CMP_W-1:0]  need_ext;
    logic              fits;
    logic              split;
    logic [SUM_W-1:0]  ns_sum;
    logic [CMP_W-1:0]  rem;
    logic [ADDR_W-1:0] hit_addr;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign need_cmd = (NEED_W'(cmd.req_bytes) + NEED_W'(3)) & ~NEED_W'(3);
    assign free_off = cmd.free_addr - heap_base - ADDR_W'(HEADER_BYTES);
    assign free_ok  = (cmd.free_addr != '0) && (free_off < ADDR_W'(HEAP_BYTES))
                      && (free_off[1:0] == 2'b00);

    assign size_ext = CMP_W'(meta_rdata.size);
    assign need_ext = CMP_W'(need_reg);
    assign fits     = flag_rdata && (size_ext >= need_ext);
    assign split    = size_ext > (need_ext + CMP_W'(HEADER_BYTES) + CMP_W'(SPLIT_SLACK));
    assign ns_sum   = SUM_W'(cur_reg) + SUM_W'(HDR_WORDS) + SUM_W'(need_reg[NEED_W-1:2]);
    assign rem      = size_ext - need_ext - CMP_W'(HEADER_BYTES);
    assign hit_addr = heap_base + ADDR_W'({cur_reg, 2'b00}) + ADDR_W'(HEADER_BYTES);

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        pend_next      = pend_reg;
        cur_next       = cur_reg;
        ns_next        = ns_reg;
        need_next      = need_reg;
        raddr          = cur_reg;
        wr             = '0;

        case (state_reg)
            ST_INIT:
            begin
                wr.flag_we     = 1'b1;
                wr.meta_we     = 1'b1;
                wr.waddr       = '0;
                wr.flag        = 1'b1;
                wr.meta.size   = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
                wr.meta.next   = '0;
                state_next     = ST_IDLE;
            end
            ST_IDLE:
            begin
                raddr = '0;
                if (accept)
                begin
                    if (cmd.func == FUNC_ALLOC)
                    begin
                        cur_next   = '0;
                        need_next  = need_cmd;
                        state_next = ST_EXAM;
                    end
                    else
                    begin
                        wr.flag_we = free_ok;
                        wr.waddr   = free_off[SLOT_W+1:2];
                        wr.flag    = 1'b1;
                        pend_next  = '0;
                        state_next = ST_RESP;
                    end
                end
            end
            ST_EXAM:
            begin
                if (fits)
                begin
                    pend_next.result_addr   = hit_addr;
                    pend_next.out_of_memory = 1'b0;
                    if (split)
                    begin
                        wr.flag_we   = 1'b1;
                        wr.meta_we   = 1'b1;
                        wr.waddr     = ns_sum[SLOT_W-1:0];
                        wr.flag      = 1'b1;
                        wr.meta.size = SIZE_W'(rem);
                        wr.meta.next = meta_rdata.next;
                        ns_next      = ns_sum[SLOT_W-1:0];
                        state_next   = ST_SPLIT;
                    end
                    else
                    begin
                        wr.flag_we = 1'b1;
                        wr.waddr   = cur_reg;
                        wr.flag    = 1'b0;
                        state_next = ST_RESP;
                    end
                end
                else if (meta_rdata.next == '0)
                begin
                    pend_next.result_addr   = '0;
                    pend_next.out_of_memory = 1'b1;
                    state_next              = ST_RESP;
                end
                else
                begin
                    raddr    = meta_rdata.next;
                    cur_next = meta_rdata.next;
                end
            end
            ST_SPLIT:
            begin
                wr.flag_we   = 1'b1;
                wr.meta_we   = 1'b1;
                wr.waddr     = cur_reg;
                wr.flag      = 1'b0;
                wr.meta.size = SIZE_W'(need_reg);
                wr.meta.next = ns_reg;
                state_next   = ST_RESP;
            end
            ST_RESP:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        pend_reg <= pend_next;
        cur_reg  <= cur_next;
        ns_reg   <= ns_next;
        need_reg <= need_next;
    end

    `ASSERT_ALWAYS(a_meta_with_flag, wr.meta_we |-> wr.flag_we)
    `ASSERT_ALWAYS(a_split_after_exam, (state_reg == ST_SPLIT) |-> ($past(state_reg) == ST_EXAM))
    `ASSERT_ALWAYS(a_oom_zero_addr, (res_valid && res.out_of_memory) |-> (res.result_addr == '0))
    `ASSERT_NEXT(a_stall_after_accept, accept, cmd_stall)

endmodule

`default_nettype wire

[src/first_fit_heap_allocator.sv]
// ============================================================================
// first_fit_heap_allocator
// First-fit heap allocator with block splitting over a fixed heap region.
// ============================================================================
// One item is in work at a time. A free is taken in ST_IDLE and goes
// straight to ST_RESP. An allocation visits the block headers on the chain
// from offset 0 in ST_EXAM and passes through ST_SPLIT when the chosen
// block is split; the header memory is read once per cycle, one header per
// read. After reset the block writes the initial free block header in
// ST_INIT before it takes a transfer.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire cmd_t              cmd,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output res_t                   res,
    input  wire logic              heap_base_we,
    input  wire logic [ADDR_W-1:0] heap_base_wdata
);

    logic [ADDR_W-1:0] heap_base_reg;
    logic [SLOT_W-1:0] raddr;
    logic              flag_rdata;
    meta_t             meta_rdata;
    hdr_wr_t           wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= HEAP_BASE_RESET;
        end
        else if (heap_base_we)
        begin
            heap_base_reg <= heap_base_wdata;
        end
    end

    ffha_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .heap_base  (heap_base_reg),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .raddr      (raddr),
        .flag_rdata (flag_rdata),
        .meta_rdata (meta_rdata),
        .wr         (wr)
    );

    ffha_ram #(
        .DATA_W (1),
        .ADDR_W (SLOT_W)
    ) u_flag_ram (
        .clk   (clk),
        .we    (wr.flag_we),
        .waddr (wr.waddr),
        .wdata (wr.flag),
        .raddr (raddr),
        .rdata (flag_rdata)
    );

    ffha_ram #(
        .DATA_W ($bits(meta_t)),
        .ADDR_W (SLOT_W)
    ) u_meta_ram (
        .clk   (clk),
        .we    (wr.meta_we),
        .waddr (wr.waddr),
        .wdata (wr.meta),
        .raddr (raddr),
        .rdata (meta_rdata)
    );

endmodule

`default_nettype wire

[tb/first_fit_heap_allocator_tb.sv]
// ============================================================================
// first_fit_heap_allocator_tb
// Self-checking bench for the first-fit heap allocator. A table of directed
// items runs first, covering heap exhaustion, zero and odd sizes, exact fits,
// the split threshold, and frees at address 0, misaligned or outside the
// region. Random allocate/release traffic follows across several heap_base
// settings and idle patterns. Each result transfer is compared with an
// in-bench model of the header chain, or with a typed row's table values.
// ============================================================================
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    localparam int QUIET_LIMIT = 4 * (DEPTH + 256);
    localparam int PHASE_ITEMS = 210;
    localparam int DIR_ROWS    = 24;

    typedef struct packed {
        logic              func;
        logic [REQ_W-1:0]  req_bytes;
        logic [ADDR_W-1:0] free_addr;
        logic              typed;
        logic [ADDR_W-1:0] want_addr;
        logic              want_oom;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_stall;
    cmd_t              cmd = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    res_t              res;
    logic              heap_base_we = 1'b0;
    logic [ADDR_W-1:0] heap_base_wdata = '0;

    bit [31:0] base_addr;
    bit [31:0] blk_size [DEPTH];
    bit        blk_free [DEPTH];
    bit [31:0] blk_next [DEPTH];

    res_t      pending_res [$];
    bit [31:0] live_payloads [$];
    dir_row_t  directed_tbl [DIR_ROWS];
    res_t      oldest;
    int        fail_count = 0;
    int        quiet_cycles = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;

    first_fit_heap_allocator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .cmd             (cmd),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res             (res),
        .heap_base_we    (heap_base_we),
        .heap_base_wdata (heap_base_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int slot_of(input bit [31:0] off);
        return int'((off >> 2) % DEPTH);
    endfunction

    function automatic res_t heap_result(input cmd_t c);
        res_t      r;
        bit [31:0] need;
        bit [31:0] cur;
        bit [31:0] noff;
        bit [31:0] off;
        int        s;
        int        ns;
        bit        done;
        r = '0;
        if (c.func == FUNC_ALLOC)
        begin
            need = ({16'd0, c.req_bytes} + 32'd3) & ~32'd3;
            cur = 0;
            done = 1'b0;
            r.out_of_memory = 1'b1;
            for (int steps = 0; steps < DEPTH && !done; steps++)
            begin
                s = slot_of(cur);
                if (blk_free[s] && blk_size[s] >= need)
                begin
                    if (blk_size[s] > need + HEADER_BYTES + SPLIT_SLACK)
                    begin
                        noff = cur + HEADER_BYTES + need;
                        ns = slot_of(noff);
                        blk_free[ns] = 1'b1;
                        blk_size[ns] = blk_size[s] - need - HEADER_BYTES;
                        blk_next[ns] = blk_next[s];
                        blk_size[s] = need;
                        blk_next[s] = noff;
                    end
                    blk_free[s] = 1'b0;
                    r.result_addr = base_addr + cur + HEADER_BYTES;
                    r.out_of_memory = 1'b0;
                    done = 1'b1;
                end
                else
                begin
                    cur = blk_next[s];
                    if (cur == 0)
                        done = 1'b1;
                end
            end
        end
        else if (c.free_addr != 0)
        begin
            off = c.free_addr - base_addr - HEADER_BYTES;
            if (off < HEAP_BYTES && off[1:0] == 2'b00)
                blk_free[slot_of(off)] = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input bit [31:0] want,
                                   input logic [31:0] got);
        if (fail_count < 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        fail_count++;
    endtask

    task automatic send_cmd(input cmd_t c);
        cmd <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_res.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[first_fit_heap_allocator] ERROR");
                $finish;
            end
            else
            begin
                if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                    quiet_cycles <= 0;
                else
                    quiet_cycles <= quiet_cycles + 1;
                if (res_valid && !res_stall)
                begin
                    if (pending_res.size() == 0)
                        report_mismatch("unexpected result_addr", 32'd0, res.result_addr);
                    else
                    begin
                        oldest = pending_res.pop_front();
                        if (res.result_addr !== oldest.result_addr)
                            report_mismatch("result_addr", oldest.result_addr,
                                            res.result_addr);
                        if (res.out_of_memory !== oldest.out_of_memory)
                            report_mismatch("out_of_memory", {31'd0, oldest.out_of_memory},
                                            {31'd0, res.out_of_memory});
                    end
                end
                res_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    initial
    begin : stimulus
        cmd_t      item;
        res_t      predicted;
        dir_row_t  row;
        bit [31:0] phase_base [8];
        int        gap;
        int        pick;
        int        idx;
        int        alloc_pct;

        for (int i = 0; i < DEPTH; i++)
        begin
            blk_size[i] = 0;
            blk_free[i] = 1'b0;
            blk_next[i] = 0;
        end
        blk_size[0] = HEAP_BYTES - HEADER_BYTES;
        blk_free[0] = 1'b1;
        base_addr = HEAP_BASE_RESET;

        directed_tbl[0]  = '{FUNC_ALLOC, 16'd0,     32'h0,         1'b1, 32'hC000_000C, 1'b0};
        directed_tbl[1]  = '{FUNC_ALLOC, 16'd1,     32'h0,         1'b1, 32'hC000_0018, 1'b0};
        directed_tbl[2]  = '{FUNC_ALLOC, 16'hFFFF,  32'h0,         1'b1, 32'h0,         1'b1};
        directed_tbl[3]  = '{FUNC_FREE,  16'hFFFF,  32'h0,         1'b1, 32'h0,         1'b0};
        directed_tbl[4]  = '{FUNC_FREE,  16'd0,     32'hFFFF_FFFF, 1'b1, 32'h0,         1'b0};
        directed_tbl[5]  = '{FUNC_FREE,  16'd0,     32'hC000_000C, 1'b1, 32'h0,         1'b0};
        directed_tbl[6]  = '{FUNC_ALLOC, 16'd0,     32'h0,         1'b1, 32'hC000_000C, 1'b0};
        directed_tbl[7]  = '{FUNC_FREE,  16'd0,     32'hC000_0018, 1'b1, 32'h0,         1'b0};
        directed_tbl[8]  = '{FUNC_ALLOC, 16'd3,     32'h0,         1'b1, 32'hC000_0018, 1'b0};
        directed_tbl[9]  = '{FUNC_ALLOC, 16'd5,     32'h0,         1'b0, 32'h0,         1'b0};
        directed_tbl[10] = '{FUNC_ALLOC, 16'd100,   32'h0,         1'b0, 32'h0,         1'b0};
        directed_tbl[11] = '{FUNC_ALLOC, 16'd4,     32'h0,         1'b0, 32'h0,         1'b0};
        directed_tbl[12] = '{FUNC_FREE,  16'd0,     32'hC000_003C, 1'b1, 32'h0,         1'b0};
        directed_tbl[13] = '{FUNC_ALLOC, 16'd72,    32'h0,         1'b0, 32'h0,         1'b0};
        directed_tbl[14] = '{FUNC_FREE,  16'd0,     32'hC000_003C, 1'b1, 32'h0,         1'b0};
        directed_tbl[15] = '{FUNC_ALLOC, 16'd68,    32'h0,         1'b0, 32'h0,         1'b0};
        directed_tbl[16] = '{FUNC_ALLOC, 16'd20,    32'h0,         1'b0, 32'h0,         1'b0};
        directed_tbl[17] = '{FUNC_FREE,  16'd0,     32'hC000_000E, 1'b1, 32'h0,         1'b0};
        directed_tbl[18] = '{FUNC_FREE,  16'd0,     32'hC001_000C, 1'b1, 32'h0,         1'b0};
        directed_tbl[19] = '{FUNC_FREE,  16'd0,     32'hC000_0008, 1'b1, 32'h0,         1'b0};
        directed_tbl[20] = '{FUNC_FREE,  16'd0,     32'hC001_0008, 1'b1, 32'h0,         1'b0};
        directed_tbl[21] = '{FUNC_ALLOC, 16'hFFFF,  32'hFFFF_FFFF, 1'b1, 32'h0,         1'b1};
        directed_tbl[22] = '{FUNC_ALLOC, 16'd60000, 32'h0,         1'b0, 32'h0,         1'b0};
        directed_tbl[23] = '{FUNC_ALLOC, 16'd0,     32'h0,         1'b0, 32'h0,         1'b0};

        phase_base[0] = HEAP_BASE_RESET;
        phase_base[1] = 32'h0000_0000;
        phase_base[2] = 32'hFFFF_FFFF;
        phase_base[3] = 32'hFFFF_FFF4;
        phase_base[4] = $urandom;
        phase_base[5] = 32'hFFFF_8000;
        phase_base[6] = $urandom;
        phase_base[7] = 32'hC000_0000;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = directed_tbl[i];
            item.func = row.func;
            item.req_bytes = row.req_bytes;
            item.free_addr = row.free_addr;
            send_cmd(item);
            predicted = heap_result(item);
            if (item.func == FUNC_ALLOC && !predicted.out_of_memory)
                live_payloads.push_back(predicted.result_addr - base_addr);
            if (row.typed)
            begin
                predicted.result_addr = row.want_addr;
                predicted.out_of_memory = row.want_oom;
            end
            pending_res.push_back(predicted);
        end

        for (int p = 0; p < 8; p++)
        begin
            drain_results();
            if (p != 0)
            begin
                heap_base_we <= 1'b1;
                heap_base_wdata <= phase_base[p];
                @(posedge clk);
                heap_base_we <= 1'b0;
                base_addr = phase_base[p];
            end
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
                default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                item.req_bytes = 16'($urandom);
                item.free_addr = $urandom;
                alloc_pct = (live_payloads.size() > 48) ? 40 : 60;
                pick = $urandom_range(99);
                if (pick < alloc_pct)
                begin
                    item.func = FUNC_ALLOC;
                    pick = $urandom_range(99);
                    if (pick < 10)
                        item.req_bytes = 16'($urandom_range(31, 0));
                    else if (pick < 70)
                        item.req_bytes = 16'($urandom_range(2047, 32));
                    else if (pick < 90)
                        item.req_bytes = 16'($urandom_range(12000, 2048));
                end
                else if (pick < 92 && live_payloads.size() != 0)
                begin
                    item.func = FUNC_FREE;
                    idx = $urandom_range(live_payloads.size() - 1);
                    item.free_addr = base_addr + live_payloads[idx];
                    live_payloads.delete(idx);
                end
                else
                begin
                    item.func = FUNC_FREE;
                    case ($urandom_range(2))
                        0: item.free_addr = 32'h0;
                        1: item.free_addr = base_addr + HEADER_BYTES
                                            + $urandom_range(HEAP_BYTES + 1023);
                        default: ;
                    endcase
                end

                send_cmd(item);
                predicted = heap_result(item);
                if (item.func == FUNC_ALLOC && !predicted.out_of_memory)
                    live_payloads.push_back(predicted.result_addr - base_addr);
                pending_res.push_back(predicted);

                gap = 0;
                while ($urandom_range(99) < tx_idle_pct)
                    gap++;
                if ($urandom_range(199) == 0)
                    drain_results();
                else if (gap > 0)
                begin
                    cmd_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        drain_results();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending_res.size() == 0)
            $display("[first_fit_heap_allocator] OK");
        else
            $display("[first_fit_heap_allocator] ERROR");
        $finish;
    end

endmodule
